// File: rtl/ohl_pkg.sv
// package for the ordered handle list: sizes, command and status codes, shared types
// no dependencies
`default_nettype none
package ohl_pkg;
    localparam int DEPTH       = 32;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_REMOVE_AT = 3'd2;
    localparam logic [2:0] CMD_REMOVE_H  = 3'd3;
    localparam logic [2:0] CMD_MOVE      = 3'd4;
    localparam logic [2:0] CMD_FIND_AT   = 3'd5;
    localparam logic [2:0] CMD_FIND_H    = 3'd6;
    localparam logic [2:0] CMD_RENUMBER  = 3'd7;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // shift kinds applied to the cell chain
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_OPEN  = 3'd1;
    localparam logic [2:0] OP_CLOSE = 3'd2;
    localparam logic [2:0] OP_MOVE  = 3'd3;
    localparam logic [2:0] OP_RENUM = 3'd4;
    localparam logic [2:0] OP_WRITE = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic                   busy;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/ordered_handle_list_unit.sv
// top level of the ordered handle list: controller plus cell-chain datapath
// depends on ohl_pkg, ohl_ctrl, ohl_dp
`default_nettype none
// Ordered list of up to 32 handle/id entries kept in a chain of cells. A
// command word is captured at acceptance, executed in the cell chain on the
// next cycle and its result word is offered in the cycle after that, held
// until it is taken. One command is in work at a time and the next word is
// taken the cycle after the result leaves. All shifts of insert, remove and
// move finish in the execute state, each cell loading from itself, a
// neighbor, the written word or, for move, the source cell.
module ordered_handle_list_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[2:0], position[8:3], to_position[13:9], handle[45:14], zero pad
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], found_handle[33:2], found_id[38:34], found_position[43:39],
    // entry_count[49:44], zero pad
    output logic [55:0]      m_axis_tdata
);
    import ohl_pkg::*;

    t_cmd        cmd;
    logic [1:0]  status;
    logic [31:0] fh;
    logic [4:0]  fid, fpos;
    logic [5:0]  cnt;

    ohl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd)
    );

    ohl_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_command(s_axis_tdata[2:0]), .i_position(s_axis_tdata[8:3]),
        .i_to_position(s_axis_tdata[13:9]), .i_handle(s_axis_tdata[45:14]),
        .o_status(status), .o_found_handle(fh), .o_found_id(fid),
        .o_found_position(fpos), .o_entry_count(cnt)
    );

    assign m_axis_tdata = {6'd0, cnt, fpos, fid, fh, status};
endmodule
`default_nettype wire

// File: rtl/ohl_ctrl.sv
// controller: takes one command word, runs it, holds the result word until taken
// depends on ohl_pkg
`default_nettype none
module ohl_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output ohl_pkg::t_cmd    o_cmd
);
    import ohl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid) else $error("exec not followed by result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: rtl/ohl_dp.sv
// datapath: registered command, cell chain of handles and ids, count, result word
// depends on ohl_pkg
`default_nettype none
module ohl_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  ohl_pkg::t_cmd               i_cmd,
    input  wire logic [2:0]             i_command,
    input  wire logic [5:0]             i_position,
    input  wire logic [4:0]             i_to_position,
    input  wire logic [31:0]            i_handle,
    output logic [1:0]                  o_status,
    output logic [31:0]                 o_found_handle,
    output logic [4:0]                  o_found_id,
    output logic [4:0]                  o_found_position,
    output logic [5:0]                  o_entry_count
);
    import ohl_pkg::*;

    logic [HANDLE_BITS-1:0] r_h   [DEPTH];
    logic [4:0]             r_id  [DEPTH];
    logic [CNT_BITS-1:0]    r_cnt;
    logic [2:0]             r_c;
    logic [5:0]             r_pos;
    logic [4:0]             r_to;
    logic [HANDLE_BITS-1:0] r_hd;

    // match vector and lowest match (priority search over the chain)
    logic [DEPTH-1:0]       hit;
    logic                   any_hit;
    logic [IDX_BITS-1:0]    hit_at;
    always_comb begin
        hit_at = '0;
        any_hit = 1'b0;
        for (int k = 0; k < DEPTH; k++)
            hit[k] = (r_h[k] == r_hd) && (CNT_BITS'(k) < r_cnt);
        for (int k = DEPTH - 1; k >= 0; k--)
            if (hit[k]) begin
                hit_at = IDX_BITS'(k);
                any_hit = 1'b1;
            end
    end

    // decode command into one chain operation
    logic [2:0]             op;
    logic [1:0]             st;
    logic [IDX_BITS-1:0]    at;
    logic [IDX_BITS-1:0]    dst;
    logic [CNT_BITS-1:0]    cnt_n;
    logic [HANDLE_BITS-1:0] wh;
    logic [4:0]             wid;
    logic [CNT_BITS:0]      pos_w, to_w;
    logic                   full;
    always_comb begin
        pos_w = (CNT_BITS+1)'(r_pos);
        to_w  = (CNT_BITS+1)'(r_to);
        full  = (r_cnt >= CNT_BITS'(DEPTH));
        op = OP_NONE; st = ST_MISS; at = '0; dst = '0; cnt_n = r_cnt;
        wh = r_hd; wid = '0;
        case (r_c)
            CMD_APPEND: if (full) st = ST_FULL; else begin
                op = OP_WRITE; st = ST_DONE; at = IDX_BITS'(r_cnt); dst = at;
                wid = 5'(r_cnt); cnt_n = r_cnt + 1'b1;
            end
            CMD_INSERT: if (pos_w > (CNT_BITS+1)'(r_cnt)) st = ST_MISS;
                else if (full) st = ST_FULL; else begin
                op = OP_OPEN; st = ST_DONE; at = IDX_BITS'(r_pos); dst = at;
                cnt_n = r_cnt + 1'b1;
            end
            CMD_REMOVE_AT: if (pos_w < (CNT_BITS+1)'(r_cnt)) begin
                op = OP_CLOSE; st = ST_DONE; at = IDX_BITS'(r_pos); dst = at;
                cnt_n = r_cnt - 1'b1;
            end
            CMD_REMOVE_H: if (r_hd != '0 && any_hit) begin
                op = OP_CLOSE; st = ST_DONE; at = hit_at; dst = at;
                cnt_n = r_cnt - 1'b1;
            end
            CMD_MOVE: if (pos_w < (CNT_BITS+1)'(r_cnt) && to_w < (CNT_BITS+1)'(r_cnt)) begin
                op = OP_MOVE; st = ST_DONE; at = IDX_BITS'(r_pos); dst = IDX_BITS'(r_to);
            end
            CMD_FIND_AT: if (pos_w < (CNT_BITS+1)'(r_cnt)) begin
                st = ST_DONE; at = IDX_BITS'(r_pos); dst = at;
            end
            CMD_FIND_H: if (any_hit) begin
                st = ST_DONE; at = hit_at; dst = at;
            end
            CMD_RENUMBER: begin
                op = OP_RENUM; st = ST_DONE;
            end
            default: op = OP_NONE;
        endcase
    end

    // per-cell next value: each cell picks self, neighbor, written word or move source
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int k = 0; k < DEPTH; k++) begin
                case (op)
                    OP_WRITE: if (IDX_BITS'(k) == at) begin
                        r_h[k] <= wh; r_id[k] <= wid;
                    end
                    OP_OPEN: if (IDX_BITS'(k) == at) begin
                        r_h[k] <= wh; r_id[k] <= '0;
                    end else if (IDX_BITS'(k) > at && k > 0) begin
                        r_h[k] <= r_h[(k+DEPTH-1)%DEPTH]; r_id[k] <= r_id[(k+DEPTH-1)%DEPTH];
                    end
                    OP_CLOSE: if (IDX_BITS'(k) >= at && k < DEPTH - 1) begin
                        r_h[k] <= r_h[(k+1)%DEPTH]; r_id[k] <= r_id[(k+1)%DEPTH];
                    end
                    OP_MOVE: if (IDX_BITS'(k) == dst) begin
                        r_h[k] <= r_h[at]; r_id[k] <= r_id[at];
                    end else if (at < dst && IDX_BITS'(k) >= at && IDX_BITS'(k) < dst
                                 && k < DEPTH - 1) begin
                        r_h[k] <= r_h[(k+1)%DEPTH]; r_id[k] <= r_id[(k+1)%DEPTH];
                    end else if (at > dst && IDX_BITS'(k) <= at && IDX_BITS'(k) > dst
                                 && k > 0) begin
                        r_h[k] <= r_h[(k+DEPTH-1)%DEPTH]; r_id[k] <= r_id[(k+DEPTH-1)%DEPTH];
                    end
                    OP_RENUM: r_id[k] <= 5'(k);
                    default: ;
                endcase
            end
        end
    end

    // command word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c <= i_command; r_pos <= i_position; r_to <= i_to_position;
            r_hd <= HANDLE_BITS'(i_handle);
        end
    end

    // count and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (i_cmd.exec) r_cnt <= cnt_n;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status      <= st;
            o_entry_count <= 6'(cnt_n);
            if (st != ST_DONE || op == OP_RENUM) begin
                o_found_handle <= '0; o_found_id <= '0; o_found_position <= '0;
            end else begin
                o_found_position <= 5'(dst);
                if (op == OP_WRITE || op == OP_OPEN) begin
                    o_found_handle <= 32'(wh); o_found_id <= wid;
                end else begin
                    o_found_handle <= 32'(r_h[at]); o_found_id <= r_id[at];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(DEPTH)) else $error("count over depth");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_cnt)) else $error("count moved while idle");
    a_full_nochg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && st == ST_FULL) |=> $stable(r_cnt)) else $error("full changed count");
`endif
endmodule
`default_nettype wire
